/* src/fnadc_pkg.sv */
// ---------------------------------------------------------------------------
// fnadc_pkg
// Shared constants and types for the four-neighbour cost block.
// ---------------------------------------------------------------------------
package fnadc_pkg;

   // result field widths
   localparam int COL_BITS        = 10;
   localparam int ROW_BITS        = 12;
   localparam int COST_BITS       = 8;
   localparam int MASK_BITS       = 4;
   localparam int RSP_PAD_BITS    = 6;
   localparam int RSP_DATA_BITS   = 64;

   // input beat
   localparam int PIXEL_IN_BITS   = 8;

   // register port
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 13;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int ROW_LIMIT       = 4096;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // neighbour mask bit positions
   localparam int MASK_UP    = 0;
   localparam int MASK_DOWN  = 1;
   localparam int MASK_LEFT  = 2;
   localparam int MASK_RIGHT = 3;

   // position flags of a captured pixel and the results it owes
   typedef struct packed {
      logic r_ge1;      // a row above exists
      logic r_ge2;      // two rows above exist
      logic x_ge1;      // a column to the left exists
      logic x_ge2;      // two columns to the left exist
      logic has_right;  // a column to the right exists
      logic do_a;       // centre above is due
      logic do_b;       // last-row centre to the left is due
      logic do_c;       // frame's final pixel reports itself
   } nbr_flags_type;

   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      nbr_flags_type       flags;
   } ctx_type;

   // result beat layout, col in the lowest bits
   typedef struct packed {
      logic [RSP_PAD_BITS-1:0]  pad;
      logic [MASK_BITS-1:0]     mask;
      logic [COST_BITS-1:0]     cost_right;
      logic [COST_BITS-1:0]     cost_left;
      logic [COST_BITS-1:0]     cost_down;
      logic [COST_BITS-1:0]     cost_up;
      logic [ROW_BITS-1:0]      row;
      logic [COL_BITS-1:0]      col;
   } rsp_data_type;

endpackage

/* src/four_neighbour_abs_difference_costs.sv */
// A pixel's context is registered first, then its results in the result register.
// Throughput: 1 pixel per cycle while each pixel yields at most one result and
//   the output is free; a last-row pixel owing 2 or 3 results holds req_tready
//   low until its last result loads; one result register, one beat per cycle.
// Reset: synchronous; clears counters, sets a 1x1 frame, empties the pipe.
//   The line memory is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// four_neighbour_abs_difference_costs
// Raster-stream four-neighbour absolute difference cost map with a
// one-word-per-column line memory (row above and row two above).
// ---------------------------------------------------------------------------
module four_neighbour_abs_difference_costs #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // pixel stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [fnadc_pkg::PIXEL_IN_BITS-1:0]    req_tdata,  // [7:0] pixel
   // result stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [9:0] col, [21:10] row, [29:22] cost_up, [37:30] cost_down,
   // [45:38] cost_left, [53:46] cost_right, [57:54] neighbour_mask, rest zero
   output logic [fnadc_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                   rsp_tlast,  // last_of_run
   output logic                                   rsp_tuser,  // [0] end_of_frame
   // register writes: index 0 frame_width, 1 frame_height
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fnadc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fnadc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   import fnadc_pkg::*;

   logic    in_fire, in_ready, csr_fire;
   ctx_type ctx;
   logic [PIXEL_BITS-1:0] c_pix, c_above, c_upup, c_above_l, c_above_r, c_left1, c_left2;

   // registers are always writable; writes restart the frame
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid & csr_ready;

   assign req_tready = in_ready;
   assign in_fire    = req_tvalid & req_tready;

   // counters, geometry and line memory; one context captured per pixel beat
   fnadc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_fire  (csr_fire),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pix_fire  (in_fire),
      .pix_in    (req_tdata),
      .ctx       (ctx),
      .c_pix     (c_pix),
      .c_above   (c_above),
      .c_upup    (c_upup),
      .c_above_l (c_above_l),
      .c_above_r (c_above_r),
      .c_left1   (c_left1),
      .c_left2   (c_left2)
   );

   // result sequencing: centre above, last-row left centre, final pixel
   fnadc_emit #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (in_fire),
      .in_ready   (in_ready),
      .ctx        (ctx),
      .c_pix      (c_pix),
      .c_above    (c_above),
      .c_upup     (c_upup),
      .c_above_l  (c_above_l),
      .c_above_r  (c_above_r),
      .c_left1    (c_left1),
      .c_left2    (c_left2),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* src/fnadc_ram.sv */
// ---------------------------------------------------------------------------
// fnadc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// Read returns the old word on a same-address write.
// ---------------------------------------------------------------------------
module fnadc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/fnadc_front.sv */
// ---------------------------------------------------------------------------
// fnadc_front
// Frame registers, raster counters and the line memory. Each memory word
// holds a column's pixel of the row above (high half) and of the row
// two above (low half). Captures one pixel context per accepted beat.
// ---------------------------------------------------------------------------
module fnadc_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_fire,
   input  logic [fnadc_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [fnadc_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic                                      pix_fire,
   input  logic [fnadc_pkg::PIXEL_IN_BITS-1:0]       pix_in,
   output fnadc_pkg::ctx_type                        ctx,
   output logic [PIXEL_BITS-1:0]                     c_pix,
   output logic [PIXEL_BITS-1:0]                     c_above,
   output logic [PIXEL_BITS-1:0]                     c_upup,
   output logic [PIXEL_BITS-1:0]                     c_above_l,
   output logic [PIXEL_BITS-1:0]                     c_above_r,
   output logic [PIXEL_BITS-1:0]                     c_left1,
   output logic [PIXEL_BITS-1:0]                     c_left2
);

   import fnadc_pkg::*;

   localparam int CW  = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
   localparam int XW  = CW > COL_BITS ? CW : COL_BITS;
   localparam int PXW = PIXEL_BITS > PIXEL_IN_BITS ? PIXEL_BITS : PIXEL_IN_BITS;
   localparam int EW  = 2 * PIXEL_BITS;

   // frame geometry, stored as last column / last row
   logic [CW-1:0]       wlast_ff;
   logic [ROW_BITS-1:0] hlast_ff;
   logic [CW-1:0]       wlast_in;
   logic [ROW_BITS-1:0] hlast_in;

   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;

   logic [WIDTH_REG_BITS-1:0]  wreq;
   logic [HEIGHT_REG_BITS-1:0] hreq;

   logic last_col, last_row;
   logic [CW-1:0]  rd_addr;
   logic [EW-1:0]  ram_rd, eff, wr_data;
   logic [PIXEL_BITS-1:0] eff_hi, eff_lo, pix;
   logic [PXW-1:0] pix_x;
   logic [XW-1:0]  col_x;

   // same-address forward (single-column frames)
   logic           fwd_ff;
   logic [EW-1:0]  fwd_data_ff;

   ctx_type               ctx_ff;
   logic [PIXEL_BITS-1:0] pix_ff, above_ff, upup_ff, above_l_ff, left1_ff, left2_ff;

   assign wreq = csr_wdata[WIDTH_REG_BITS-1:0];
   assign hreq = csr_wdata[HEIGHT_REG_BITS-1:0];

   // clamp register values into range
   always_comb begin
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      if (csr_fire && csr_index == CSR_FRAME_WIDTH) begin
         if (wreq == '0) begin
            wlast_in = '0;
         end else if (int'(wreq) > MAX_WIDTH) begin
            wlast_in = CW'(MAX_WIDTH - 1);
         end else begin
            wlast_in = CW'(wreq - 1'b1);
         end
      end
      if (csr_fire && csr_index == CSR_FRAME_HEIGHT) begin
         if (hreq == '0) begin
            hlast_in = '0;
         end else if (hreq > HEIGHT_REG_BITS'(ROW_LIMIT)) begin
            hlast_in = ROW_BITS'(ROW_LIMIT - 1);
         end else begin
            hlast_in = ROW_BITS'(hreq - 1'b1);
         end
      end
   end

   assign last_col = (col_ff == wlast_ff);
   assign last_row = (row_ff == hlast_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_fire) begin
         col_in = '0;
         row_in = '0;
      end else if (pix_fire) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : ROW_BITS'(row_ff + 1'b1);
         end else begin
            col_in = CW'(col_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= '0;
         hlast_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         wlast_ff <= wlast_in;
         hlast_ff <= hlast_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (pix_fire) begin
            fwd_ff <= (rd_addr == col_ff);
         end
      end
   end

   assign pix_x = PXW'(pix_in);
   assign pix   = pix_x[PIXEL_BITS-1:0];

   // prefetch the next column's word; wraps to column 0 for the next row
   assign rd_addr = last_col ? '0 : CW'(col_ff + 1'b1);

   assign eff     = fwd_ff ? fwd_data_ff : ram_rd;
   assign eff_hi  = eff[EW-1:PIXEL_BITS];
   assign eff_lo  = eff[PIXEL_BITS-1:0];
   assign wr_data = {pix, eff_hi};

   fnadc_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (pix_fire),
      .wr_addr (col_ff),
      .wr_data (wr_data),
      .rd_en   (pix_fire),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign col_x = XW'(col_ff);

   always_ff @(posedge clock) begin
      if (pix_fire) begin
         fwd_data_ff <= wr_data;
         pix_ff      <= pix;
         above_ff    <= eff_hi;
         upup_ff     <= eff_lo;
         above_l_ff  <= above_ff;
         left1_ff    <= pix_ff;
         left2_ff    <= left1_ff;
         ctx_ff.col             <= col_x[COL_BITS-1:0];
         ctx_ff.row             <= row_ff;
         ctx_ff.flags.r_ge1     <= (row_ff != '0);
         ctx_ff.flags.r_ge2     <= (row_ff > ROW_BITS'(1));
         ctx_ff.flags.x_ge1     <= (col_ff != '0);
         ctx_ff.flags.x_ge2     <= (XW'(col_ff) > XW'(1));
         ctx_ff.flags.has_right <= !last_col;
         ctx_ff.flags.do_a      <= (row_ff != '0);
         ctx_ff.flags.do_b      <= last_row && (col_ff != '0);
         ctx_ff.flags.do_c      <= last_row && last_col;
      end
   end

   assign ctx       = ctx_ff;
   assign c_pix     = pix_ff;
   assign c_above   = above_ff;
   assign c_upup    = upup_ff;
   assign c_above_l = above_l_ff;
   assign c_left1   = left1_ff;
   assign c_left2   = left2_ff;
   // word read at the last accept: row above, one column right
   assign c_above_r = eff_hi;

endmodule

/* src/fnadc_emit.sv */
// ---------------------------------------------------------------------------
// fnadc_emit
// Steps through the up to three results owed by the captured pixel and
// loads them one per cycle into the result register while it is free.
// ---------------------------------------------------------------------------
module fnadc_emit #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_fire,
   output logic                                   in_ready,
   input  fnadc_pkg::ctx_type                     ctx,
   input  logic [PIXEL_BITS-1:0]                  c_pix,
   input  logic [PIXEL_BITS-1:0]                  c_above,
   input  logic [PIXEL_BITS-1:0]                  c_upup,
   input  logic [PIXEL_BITS-1:0]                  c_above_l,
   input  logic [PIXEL_BITS-1:0]                  c_above_r,
   input  logic [PIXEL_BITS-1:0]                  c_left1,
   input  logic [PIXEL_BITS-1:0]                  c_left2,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [fnadc_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser
);

   import fnadc_pkg::*;

   localparam int CXW = PIXEL_BITS > COST_BITS ? PIXEL_BITS : COST_BITS;

   function automatic logic [COST_BITS-1:0] cost(
      input logic [PIXEL_BITS-1:0] a,
      input logic [PIXEL_BITS-1:0] b,
      input logic                  en
   );
      logic [PIXEL_BITS-1:0] d;
      logic [CXW-1:0]        dx;
      begin
         d  = (a > b) ? PIXEL_BITS'(a - b) : PIXEL_BITS'(b - a);
         dx = CXW'(d);
         return en ? dx[COST_BITS-1:0] : '0;
      end
   endfunction

   // pend bit0: centre above, bit1: last-row left centre, bit2: final pixel
   logic [2:0] pend_ff, pend_in, pend_cur, pend_rem;
   logic       fresh_ff, fresh_in;   // ctx captured at the last edge, run taken from its flags
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, emit_now, sel_a, sel_b;

   rsp_data_type          data_ff, data_nx;
   logic                  last_ff, eof_ff;
   logic [PIXEL_BITS-1:0] v_c, v_up, v_dn, v_lf, v_rt;
   logic [MASK_BITS-1:0]  m;

   assign pend_cur = fresh_ff ? {ctx.flags.do_c, ctx.flags.do_b, ctx.flags.do_a} : pend_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit_now = (pend_cur != '0) && out_free;
   assign sel_a    = pend_cur[0];
   assign sel_b    = !pend_cur[0] && pend_cur[1];
   assign pend_rem = pend_cur & (pend_cur - 3'd1);
   assign in_ready = out_free ? (pend_rem == '0) : (pend_cur == '0);

   always_comb begin
      pend_in  = pend_cur;
      fresh_in = in_fire;
      if (in_fire) begin
         // old run is done; the new one comes from ctx next cycle
         pend_in = '0;
      end else if (emit_now) begin
         pend_in = pend_rem;
      end
      rsp_valid_in = emit_now ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      m = '0;
      data_nx = '0;
      if (sel_a) begin
         data_nx.col     = ctx.col;
         data_nx.row     = ROW_BITS'(ctx.row - 1'b1);
         v_c = c_above; v_up = c_upup; v_dn = c_pix; v_lf = c_above_l; v_rt = c_above_r;
         m[MASK_UP]    = ctx.flags.r_ge2;
         m[MASK_DOWN]  = 1'b1;
         m[MASK_LEFT]  = ctx.flags.x_ge1;
         m[MASK_RIGHT] = ctx.flags.has_right;
      end else if (sel_b) begin
         data_nx.col     = COL_BITS'(ctx.col - 1'b1);
         data_nx.row     = ctx.row;
         v_c = c_left1; v_up = c_above_l; v_dn = c_pix; v_lf = c_left2; v_rt = c_pix;
         m[MASK_UP]    = ctx.flags.r_ge1;
         m[MASK_LEFT]  = ctx.flags.x_ge2;
         m[MASK_RIGHT] = 1'b1;
      end else begin
         data_nx.col     = ctx.col;
         data_nx.row     = ctx.row;
         v_c = c_pix; v_up = c_above; v_dn = c_pix; v_lf = c_left1; v_rt = c_pix;
         m[MASK_UP]    = ctx.flags.r_ge1;
         m[MASK_LEFT]  = ctx.flags.x_ge1;
      end
      data_nx.cost_up    = cost(v_c, v_up, m[MASK_UP]);
      data_nx.cost_down  = cost(v_c, v_dn, m[MASK_DOWN]);
      data_nx.cost_left  = cost(v_c, v_lf, m[MASK_LEFT]);
      data_nx.cost_right = cost(v_c, v_rt, m[MASK_RIGHT]);
      data_nx.mask       = m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_now) begin
         data_ff <= data_nx;
         last_ff <= (pend_rem == '0);
         eof_ff  <= !sel_a && !sel_b;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = eof_ff;

endmodule

/* src/fnadc_checker.sv */
// ---------------------------------------------------------------------------
// fnadc_checker
// Port-level checks on the cost block, bound to the top level.
// ---------------------------------------------------------------------------
module fnadc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [fnadc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                                rsp_tlast,
   input logic                                rsp_tuser
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // frame's final result closes its run
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end_of_frame without last_of_run");

   // final pixel has no down or right neighbour
   a_eof_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[55] && !rsp_tdata[57])
      else $error("end_of_frame beat with down or right neighbour");

   // more results of this pixel are owed: no new pixel while output stalls
   a_run_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast && !rsp_tready |-> !(req_tvalid && req_tready))
      else $error("pixel accepted with results still owed");

endmodule

bind four_neighbour_abs_difference_costs fnadc_checker u_fnadc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

/* tb/sv/four_neighbour_abs_difference_costs_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// four_neighbour_abs_difference_costs_tb
// Self-checking bench for the four-neighbour edge cost block. Pixels are
// streamed in raster order under random gaps and result back-pressure. A
// behavioral line-store predictor builds the expected cost beats at each
// pixel handshake, and a monitor compares every result beat with them.
// ---------------------------------------------------------------------------
module four_neighbour_abs_difference_costs_tb;
   import fnadc_pkg::*;

   localparam int MAX_W         = 1024;
   localparam int SETTLE_CYCLES = 8;         // pipe is 2 deep; margin on top
   localparam int HOLD_CYCLES   = 80;        // long receiver hold-off
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int WIDE_ITEMS    = 48;
   localparam int RANDOM_ITEMS  = 262;

   // one expected result beat: data word plus tlast and tuser
   typedef struct packed {
      rsp_data_type data;
      logic         last;
      logic         eof;
   } cost_beat_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [PIXEL_IN_BITS-1:0]    req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]    rsp_tdata;
   logic                        rsp_tlast;
   logic                        rsp_tuser;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;

   // predictor state: two line banks, raster position, register copies
   logic [7:0]                  line_mem [0:2*MAX_W-1];
   logic [WIDTH_REG_BITS-1:0]   width_reg;
   logic [HEIGHT_REG_BITS-1:0]  height_reg;
   int unsigned                 col_pos;
   int unsigned                 row_pos;
   bit                          bank;
   cost_beat_type               cost_queue [$];   // expected beats, oldest first

   int                          error_count = 0;
   int                          pixels_sent = 0;
   bit                          steady = 1'b0;    // no gaps on either side
   int                          hold_requests = 0;
   int                          holds_served = 0;
   int                          ready_hold = 0;
   int                          ready_wait = 0;
   int unsigned                 cycle_count = 0;
   cost_beat_type               want;
   rsp_data_type                got;

   four_neighbour_abs_difference_costs #(
      .MAX_WIDTH  (MAX_W),
      .PIXEL_BITS (8)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // out-of-range register values clamp into 1..MAX_W and 1..ROW_LIMIT
   function automatic int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
   endfunction

   function automatic int unsigned active_height();
      if (height_reg == 0) return 1;
      if (height_reg > ROW_LIMIT) return ROW_LIMIT;
      return height_reg;
   endfunction

   function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [7:0] stored(bit b, int unsigned c);
      return line_mem[{b, c[9:0]}];
   endfunction

   // costs are forced to zero wherever the neighbour lies outside the frame
   function automatic void push_cost(int unsigned col, int unsigned row, logic [7:0] c,
                                     logic [7:0] up, logic [7:0] dn, logic [7:0] lf,
                                     logic [7:0] rt, logic [3:0] mask, logic last,
                                     logic eof);
      cost_beat_type b;
      b = '0;
      b.data.col        = col[COL_BITS-1:0];
      b.data.row        = row[ROW_BITS-1:0];
      b.data.cost_up    = mask[MASK_UP]    ? abs_diff(c, up) : 8'd0;
      b.data.cost_down  = mask[MASK_DOWN]  ? abs_diff(c, dn) : 8'd0;
      b.data.cost_left  = mask[MASK_LEFT]  ? abs_diff(c, lf) : 8'd0;
      b.data.cost_right = mask[MASK_RIGHT] ? abs_diff(c, rt) : 8'd0;
      b.data.mask       = mask;
      b.last            = last;
      b.eof             = eof;
      cost_queue = {cost_queue, b};
   endfunction

   // a register write restarts the frame; banks and bank select survive
   function automatic void apply_reg(logic [CSR_INDEX_BITS-1:0] idx,
                                     logic [CSR_DATA_BITS-1:0] val);
      case (idx)
         CSR_FRAME_WIDTH:  width_reg  = val[WIDTH_REG_BITS-1:0];
         CSR_FRAME_HEIGHT: height_reg = val[HEIGHT_REG_BITS-1:0];
         default: ;
      endcase
      col_pos = 0;
      row_pos = 0;
   endfunction

   // One accepted pixel releases, in this order: the centre above it, the
   // last-row centre to its left, and itself when it closes the frame.
   function automatic void predict_pixel(logic [7:0] p);
      int unsigned w, h, x, r;
      bit          cur, oth, due_above, due_left, due_self;
      logic [3:0]  mask;
      logic [7:0]  up, lf, rt;
      w = active_width();
      h = active_height();
      x = col_pos;
      r = row_pos;
      cur = bank;
      oth = ~bank;
      due_above = (r >= 1);
      due_left  = (r == h - 1) && (x >= 1);
      due_self  = (r == h - 1) && (x == w - 1);

      if (due_above) begin
         mask = 4'b0;
         mask[MASK_DOWN] = 1'b1;
         up = 8'd0; lf = 8'd0; rt = 8'd0;
         if (r >= 2) begin
            mask[MASK_UP] = 1'b1;
            up = stored(cur, x);
         end
         if (x >= 1) begin
            mask[MASK_LEFT] = 1'b1;
            lf = stored(oth, x - 1);
         end
         if (x + 1 < w) begin
            mask[MASK_RIGHT] = 1'b1;
            rt = stored(oth, x + 1);
         end
         push_cost(x, r - 1, stored(oth, x), up, p, lf, rt, mask,
                   !(due_left || due_self), 1'b0);
      end

      line_mem[{cur, x[9:0]}] = p;

      if (due_left) begin
         mask = 4'b0;
         mask[MASK_RIGHT] = 1'b1;
         up = 8'd0; lf = 8'd0;
         if (r >= 1) begin
            mask[MASK_UP] = 1'b1;
            up = stored(oth, x - 1);
         end
         if (x >= 2) begin
            mask[MASK_LEFT] = 1'b1;
            lf = stored(cur, x - 2);
         end
         push_cost(x - 1, r, stored(cur, x - 1), up, 8'd0, lf, p, mask, !due_self, 1'b0);
      end

      if (due_self) begin
         mask = 4'b0;
         up = 8'd0; lf = 8'd0;
         if (r >= 1) begin
            mask[MASK_UP] = 1'b1;
            up = stored(oth, x);
         end
         if (x >= 1) begin
            mask[MASK_LEFT] = 1'b1;
            lf = stored(cur, x - 1);
         end
         push_cost(x, r, p, up, 8'd0, lf, 8'd0, mask, 1'b1, 1'b1);
      end

      // advance raster position; bank flips at each row end
      x++;
      if (x >= w) begin
         x = 0;
         bank = oth;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = x;
      row_pos = r;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = int'($urandom_range(0, 99));
      if (roll < 55) return 0;
      if (roll < 96) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   function automatic logic [7:0] rand_pixel();
      int roll;
      roll = int'($urandom_range(0, 9));
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // one pixel beat; valid stays high into the next call when no gap is drawn
   task automatic send_pixel(input logic [7:0] p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      predict_pixel(p);
      pixels_sent++;
   endtask

   // stop offering pixels and wait for every owed beat, then let the pipe
   // settle in case the last pixels owed nothing
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (cost_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers back to back, valid held high between the two beats
   task automatic write_frame_size(input int w, input int h);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= w[CSR_DATA_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      apply_reg(CSR_FRAME_WIDTH, w[CSR_DATA_BITS-1:0]);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h[CSR_DATA_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      apply_reg(CSR_FRAME_HEIGHT, h[CSR_DATA_BITS-1:0]);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset leaves a 1x1 frame: each pixel is a whole frame, one beat, no
   // neighbours; alternating patterns toggle every pixel bit
   task automatic test_default_frame();
      send_pixel(8'hAA);
      send_pixel(8'h55);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      drain_results();
   endtask

   // 3x3 checkerboard of 0/255, last pixel 0x11: full-scale costs, every mask
   // shape, and a last row where one pixel releases three beats
   task automatic test_small_frame();
      write_frame_size(3, 3);
      send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h00);
      send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'hFF);
      send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h11);
      drain_results();
   endtask

   // zero and oversize register values clamp
   task automatic test_register_limits();
      write_frame_size(0, 0);                  // acts as 1x1
      send_pixel(8'd7);
      send_pixel(8'd200);
      write_frame_size(1, 13'h1FFF);           // height clamps to 4096
      repeat (4) send_pixel(rand_pixel());
      write_frame_size(13'h1FFF, ROW_LIMIT);   // width field 2047, clamps to 1024
      repeat (3) send_pixel(rand_pixel());     // first row only: owes nothing
      drain_results();
   endtask

   // a write in the middle of a frame starts the next one over from 0,0
   task automatic test_mid_frame_restart();
      write_frame_size(4, 3);
      repeat (6) send_pixel(rand_pixel());
      write_frame_size(4, 3);
      repeat (12) send_pixel(rand_pixel());
      drain_results();
   endtask

   // widest setting on a single-row frame; the partial row is cut off by
   // the next register write, every pixel after the first owes one beat
   task automatic test_widest_row();
      write_frame_size(MAX_W, 1);
      repeat (WIDE_ITEMS) send_pixel(rand_pixel());
      drain_results();
   endtask

   // receiver holds off while the sender keeps offering, so the block fills
   // and drops req_tready; then the sender waits for a full drain
   task automatic test_backpressure();
      write_frame_size(5, 4);
      steady = 1'b1;
      hold_requests++;
      repeat (40) send_pixel(rand_pixel());
      drain_results();
      steady = 1'b0;
      repeat (20) send_pixel(rand_pixel());
      drain_results();
   endtask

   // random frame sizes, one to three frames each, sometimes a trailing
   // partial frame cut off by the next register write
   task automatic test_random_frames();
      int start, w, h, area, n, roll;
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_ITEMS) begin
         roll = int'($urandom_range(0, 19));
         if (roll == 0)      w = 0;
         else if (roll < 14) w = int'($urandom_range(1, 6));
         else if (roll < 19) w = int'($urandom_range(7, 20));
         else                w = int'($urandom_range(21, 48));
         roll = int'($urandom_range(0, 19));
         if (roll == 0)      h = 0;
         else if (roll < 15) h = int'($urandom_range(1, 4));
         else                h = int'($urandom_range(5, 10));
         write_frame_size(w, h);
         area = int'(active_width() * active_height());
         n = (area > 60) ? area : area * int'($urandom_range(1, 3));
         if (area > 1 && $urandom_range(0, 4) == 0)
            n += int'($urandom_range(1, area - 1));
         if (n > RANDOM_ITEMS - (pixels_sent - start))
            n = RANDOM_ITEMS - (pixels_sent - start);
         steady = ($urandom_range(0, 4) == 0);
         repeat (n) send_pixel(rand_pixel());
         drain_results();
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // receiver: random ready with an occasional long hold-off
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_wait = 0;
      end else begin
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            ready_hold = HOLD_CYCLES;
         end
         if (ready_hold > 0) begin
            rsp_tready <= 1'b0;
            ready_hold--;
         end else if (ready_wait > 0) begin
            rsp_tready <= 1'b0;
            ready_wait--;
         end else begin
            rsp_tready <= 1'b1;
            ready_wait = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------
   function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch at col %0d row %0d: expected %0d, actual %0d",
                  $time, name, want.data.col, want.data.row, exp_v, act_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (cost_queue.size() == 0) begin
            $display("%0t: unexpected result beat col %0d row %0d", $time, got.col, got.row);
            error_count++;
         end else begin
            want = cost_queue.pop_front();
            check_field("col",            want.data.col,        got.col);
            check_field("row",            want.data.row,        got.row);
            check_field("cost_up",        want.data.cost_up,    got.cost_up);
            check_field("cost_down",      want.data.cost_down,  got.cost_down);
            check_field("cost_left",      want.data.cost_left,  got.cost_left);
            check_field("cost_right",     want.data.cost_right, got.cost_right);
            check_field("neighbour_mask", want.data.mask,       got.mask);
            check_field("tdata padding",  want.data.pad,        got.pad);
            check_field("last_of_run",    want.last,            rsp_tlast);
            check_field("end_of_frame",   want.eof,             rsp_tuser);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d beats still owed", $time, cost_queue.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_FRAME_WIDTH;
      csr_wdata  <= '0;
      // predictor mirrors the reset state: 1x1 frame, position 0,0, bank 0
      for (int i = 0; i < 2 * MAX_W; i++) line_mem[i] = 8'd0;
      width_reg  = 1;
      height_reg = 1;
      col_pos    = 0;
      row_pos    = 0;
      bank       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_default_frame();
      test_small_frame();
      test_register_limits();
      test_mid_frame_restart();
      test_widest_row();
      test_backpressure();
      test_random_frames();
      drain_results();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
src/fnadc_pkg.sv
src/fnadc_ram.sv
src/fnadc_front.sv
src/fnadc_emit.sv
src/four_neighbour_abs_difference_costs.sv
src/fnadc_checker.sv
tb/sv/four_neighbour_abs_difference_costs_tb.sv
